// ===== sv/multi_mode_motor_current_controller_macros.svh =====
// Assertion macros for the multi-mode motor current controller.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef MULTI_MODE_MOTOR_CURRENT_CONTROLLER_MACROS_SVH
`define MULTI_MODE_MOTOR_CURRENT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MMCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MMCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mmcc_pkg.sv =====
// Package of the multi-mode motor current controller: widths, register
// indexes, mode codes, limits, reciprocal constants and the sequencer states.
// No dependencies.
package mmcc_pkg;

  localparam int MOTOR_COUNT_DEF = 4;

  localparam int MOTOR_W     = 2;
  localparam int MODE_W      = 3;
  localparam int GAIN_W      = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;
  localparam int CUR_W       = 15;
  localparam int TERM_W      = 40;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KP      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KI      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_K_OUTER = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_K_LEG   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_KP_ENC  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_KI_ENC  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_KD_ENC  = 3'd7;

  // Mode codes; codes above MODE_ENC_PI give a zero current
  localparam logic [MODE_W-1:0] MODE_POS_PI  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VEL_PI  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CASCADE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEG_ODD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LEG_SYM = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ENC_PI  = 3'd5;

  // Reset values of the registers
  localparam logic [MODE_W-1:0] MODE_RST    = MODE_LEG_SYM;
  localparam logic [GAIN_W-1:0] KP_RST      = 16'd3328;
  localparam logic [GAIN_W-1:0] KI_RST      = 16'd1536;
  localparam logic [GAIN_W-1:0] K_OUTER_RST = 16'd3840;
  localparam logic [GAIN_W-1:0] K_LEG_RST   = 16'd2560;
  localparam logic [GAIN_W-1:0] KP_ENC_RST  = 16'd3840;
  localparam logic [GAIN_W-1:0] KI_ENC_RST  = 16'd1280;
  localparam logic [GAIN_W-1:0] KD_ENC_RST  = 16'd2560;

  // Limits
  localparam int OUT_LIMIT         = 15000;
  localparam int ENC_OUT_LIMIT     = 3000;
  localparam int VEL_SUM_LIMIT     = 16667;
  localparam int VEL_ERR_LIMIT     = 1000;
  localparam int CASCADE_ERR_LIMIT = 4000;
  localparam int LEG_HI            = 360;
  localparam int LEG_ODD_VALUE     = 300;
  localparam int DIFF_LIMIT        = 500;

  // floor(x / n) = (x * RECIP_n) >> shift, exact for any 32-bit unsigned x
  localparam logic [31:0] RECIP_3   = 32'hAAAA_AAAB;  // shift 33
  localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;  // shift 35
  localparam logic [31:0] RECIP_100 = 32'h51EB_851F;  // shift 37

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_OMUL,
    ST_ORCP,
    ST_OFIN,
    ST_VEL,
    ST_ACC,
    ST_MUL1,
    ST_MUL2,
    ST_RCP2,
    ST_TERM2,
    ST_SUM
  } st_t;

endpackage

// ===== sv/multi_mode_motor_current_controller.sv =====
// Multi-mode motor current controller: cascaded PI / PD current command per motor.
// It takes one item at a time: the input is ready only while the sequencer is idle,
// and an ignored tick goes straight to the result step.
// The block has one shared 32x32 multiplier that every gain product and every
// reciprocal division (by 3, 10, 100) passes through in turn under the sequencer.
// Synchronous active-low reset: gains and mode to defaults, integrals cleared at once.
module multi_mode_motor_current_controller #(
  parameter int MOTOR_COUNT = mmcc_pkg::MOTOR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mmcc_pkg::IN_TDATA_W-1:0]  in_tdata,   // target[31:0], measured[63:32], speed[79:64]
  input  logic [mmcc_pkg::MOTOR_W-1:0]     in_tuser,   // motor_index[1:0]
  // result item channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mmcc_pkg::OUT_TDATA_W-1:0] out_tdata,  // drive_current[14:0], zero[15]
  output logic [mmcc_pkg::MOTOR_W-1:0]     out_tuser,  // out_motor[1:0]
  // configuration write port
  input  logic                             cfg_we,
  input  logic [mmcc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mmcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mmcc_pkg::*;

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // 33-bit signed limits for the clamp helper
  localparam logic signed [32:0] SAT32_HI   = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] SAT32_LO   = 33'sh1_8000_0000;
  localparam logic signed [32:0] SAT16_HI   = 33'sd32767;
  localparam logic signed [32:0] SAT16_LO   = -33'sd32768;
  localparam logic signed [32:0] VEL_ERR_C  = 33'(VEL_ERR_LIMIT);
  localparam logic signed [32:0] VEL_SUM_C  = 33'(VEL_SUM_LIMIT);
  localparam logic signed [32:0] CASC_ERR_C = 33'(CASCADE_ERR_LIMIT);
  localparam logic signed [32:0] LEG_HI_C   = 33'(LEG_HI);
  localparam logic signed [32:0] LEG_ODD_C  = 33'(LEG_ODD_VALUE);
  localparam logic signed [32:0] DIFF_C     = 33'(DIFF_LIMIT);
  localparam logic signed [TERM_W:0] OUT_LIM_C = (TERM_W+1)'(OUT_LIMIT);
  localparam logic signed [TERM_W:0] ENC_LIM_C = (TERM_W+1)'(ENC_OUT_LIMIT);

  function automatic logic signed [32:0] clamp33(input logic signed [32:0] v,
                                                input logic signed [32:0] lo,
                                                input logic signed [32:0] hi);
    logic signed [32:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Apply a sign to a truncated product magnitude.
  function automatic logic signed [TERM_W-1:0] signed_term(input logic [TERM_W-2:0] mag,
                                                          input logic neg);
    logic signed [TERM_W-1:0] m;
    m = $signed({1'b0, mag});
    return neg ? -m : m;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_r;
  logic [GAIN_W-1:0] kp_r, ki_r, k_outer_r, k_leg_r, kp_enc_r, ki_enc_r, kd_enc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RST;
      kp_r      <= KP_RST;
      ki_r      <= KI_RST;
      k_outer_r <= K_OUTER_RST;
      k_leg_r   <= K_LEG_RST;
      kp_enc_r  <= KP_ENC_RST;
      ki_enc_r  <= KI_ENC_RST;
      kd_enc_r  <= KD_ENC_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:    mode_r    <= cfg_wdata[MODE_W-1:0];
        REG_KP:      kp_r      <= cfg_wdata;
        REG_KI:      ki_r      <= cfg_wdata;
        REG_K_OUTER: k_outer_r <= cfg_wdata;
        REG_K_LEG:   k_leg_r   <= cfg_wdata;
        REG_KP_ENC:  kp_enc_r  <= cfg_wdata;
        REG_KI_ENC:  ki_enc_r  <= cfg_wdata;
        REG_KD_ENC:  kd_enc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Mode groups
  logic mode_ok, m_kp_grp, m_div10, m_enc, m_casc, m_vel;
  assign mode_ok  = mode_r inside {[MODE_POS_PI:MODE_ENC_PI]};
  assign m_kp_grp = mode_r inside {MODE_POS_PI, MODE_VEL_PI, MODE_CASCADE};
  assign m_div10  = mode_r inside {MODE_VEL_PI, MODE_CASCADE, MODE_LEG_ODD, MODE_LEG_SYM};
  assign m_enc    = (mode_r == MODE_ENC_PI);
  assign m_casc   = (mode_r == MODE_CASCADE);
  assign m_vel    = (mode_r == MODE_VEL_PI);

  // ---------------------------------------------------------------------------
  // Per-motor state
  // ---------------------------------------------------------------------------
  logic signed [31:0] pos_sum_r [MOTOR_COUNT];
  logic signed [31:0] enc_sum_r [MOTOR_COUNT];
  logic signed [15:0] vel_sum_r [MOTOR_COUNT];  // always within +-16667
  logic signed [15:0] last_ve_r [MOTOR_COUNT];

  // ---------------------------------------------------------------------------
  // Input capture
  // ---------------------------------------------------------------------------
  st_t state_r, state_nxt;
  logic in_accept, motor_ok;
  logic signed [31:0] in_tgt, in_meas;
  logic signed [15:0] in_spd;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_tgt    = $signed(in_tdata[31:0]);
  assign in_meas   = $signed(in_tdata[63:32]);
  assign in_spd    = $signed(in_tdata[79:64]);
  assign motor_ok  = (32'(in_tuser) < MOTOR_COUNT);

  logic [MOTOR_W-1:0] motor_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [31:0] tgt_r;
  logic signed [15:0] spd_r;
  logic signed [32:0] d_r;   // target - measured, never overflows 33 bits
  logic               byp_r; // tick gives zero and leaves state alone

  always_ff @(posedge clk) begin
    if (in_accept) begin
      motor_r <= in_tuser;
      idx_r   <= IDX_W'(in_tuser);
      tgt_r   <= in_tgt;
      spd_r   <= in_spd;
      d_r     <= 33'(in_tgt) - 33'(in_meas);
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers and the shared multiplier
  // ---------------------------------------------------------------------------
  logic signed [31:0]       e_r, e_nxt;   // error, then target velocity, then vd
  logic signed [31:0]       s_r, s_nxt;   // integral or derivative operand
  logic [63:0]              p_r, p_nxt;   // registered product
  logic [31:0]              g2_r, g2_nxt; // gain of the second term
  logic signed [TERM_W-1:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic [MOTOR_W-1:0]       out_motor_r, out_motor_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Magnitudes for the unsigned multiplier; truncation toward zero is then a floor.
  logic [31:0] e_mag, s_mag, d_mag;
  logic signed [32:0] d_neg;
  assign d_neg = -d_r;
  assign e_mag = e_r[31] ? 32'(-e_r) : 32'(e_r);
  assign s_mag = s_r[31] ? 32'(-s_r) : 32'(s_r);
  assign d_mag = d_r[32] ? d_neg[31:0] : d_r[31:0];

  // 19 = 16 + 2 + 1
  logic [31:0] ki19, kd19;
  assign ki19 = (32'(ki_r) << 4) + (32'(ki_r) << 1) + 32'(ki_r);
  assign kd19 = (32'(kd_enc_r) << 4) + (32'(kd_enc_r) << 1) + 32'(kd_enc_r);

  // Outer loop result: cascade divides by 25600, encoder by 3, leg by 256.
  logic [31:0]        om;
  logic               ov_neg;
  logic signed [31:0] ov;
  always_comb begin
    case (mode_r)
      MODE_CASCADE: om = 32'(p_r[63:37]);
      MODE_ENC_PI:  om = 32'(p_r[63:33]);
      default:      om = p_r[39:8];
    endcase
    ov_neg = m_enc ? d_r[32] : e_r[31];
    ov     = ov_neg ? -$signed(om) : $signed(om);
  end

  // Velocity error and accumulation operands
  logic signed [15:0] vd;
  logic signed [32:0] vdiff;
  assign vd    = e_r[15:0];
  assign vdiff = 33'(vd) - 33'(spd_r);

  // Final sum and output clamp
  logic signed [TERM_W:0]  total, lim, total_c;
  logic [CUR_W-1:0]        cur;
  logic                    slot_free;
  always_comb begin
    total = (TERM_W+1)'(t1_r) + (TERM_W+1)'(t2_r);
    lim   = m_enc ? ENC_LIM_C : OUT_LIM_C;
    if (total > lim) begin
      total_c = lim;
    end else if (total < -lim) begin
      total_c = -lim;
    end else begin
      total_c = total;
    end
    cur = byp_r ? '0 : total_c[CUR_W-1:0];
  end
  assign slot_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (motor_ok && mode_ok) ? ST_ERR : ST_SUM;
        end
      end
      ST_ERR: begin
        if (mode_r == MODE_POS_PI) begin
          state_nxt = ST_ACC;
        end else if (m_vel) begin
          state_nxt = ST_VEL;
        end else begin
          state_nxt = ST_OMUL;
        end
      end
      ST_OMUL:  state_nxt = m_casc ? ST_ORCP : ST_OFIN;
      ST_ORCP:  state_nxt = ST_OFIN;
      ST_OFIN:  state_nxt = m_enc ? ST_ACC : ST_VEL;
      ST_VEL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = m_div10 ? ST_RCP2 : ST_TERM2;
      ST_RCP2:  state_nxt = ST_TERM2;
      ST_TERM2: state_nxt = ST_SUM;
      ST_SUM: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    e_nxt         = e_r;
    s_nxt         = s_r;
    p_nxt         = p_r;
    g2_nxt        = g2_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    mul_a         = '0;
    mul_b         = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_motor_nxt = out_motor_r;
    case (state_r)
      ST_ERR: begin
        // shape the error the mode works from
        case (mode_r)
          MODE_VEL_PI:  e_nxt = 32'(clamp33(33'(tgt_r), SAT16_LO, SAT16_HI));
          MODE_CASCADE: e_nxt = 32'(clamp33(d_r, -CASC_ERR_C, CASC_ERR_C));
          MODE_LEG_ODD: begin
            // above the high bound snaps to the lower magnitude
            if (d_r > LEG_HI_C) begin
              e_nxt = 32'(LEG_ODD_C);
            end else if (d_r < -LEG_ODD_C) begin
              e_nxt = 32'(-LEG_ODD_C);
            end else begin
              e_nxt = d_r[31:0];
            end
          end
          MODE_LEG_SYM: e_nxt = 32'(clamp33(d_r, -LEG_HI_C, LEG_HI_C));
          default:      e_nxt = 32'(clamp33(d_r, SAT32_LO, SAT32_HI));
        endcase
      end
      ST_OMUL: begin
        if (m_enc) begin
          mul_a = RECIP_3;
          mul_b = d_mag;
        end else begin
          mul_a = m_casc ? 32'(k_outer_r) : 32'(k_leg_r);
          mul_b = e_mag;
        end
        p_nxt = mul_p;
      end
      ST_ORCP: begin
        mul_a = RECIP_100;
        mul_b = p_r[39:8];
        p_nxt = mul_p;
      end
      ST_OFIN: begin
        e_nxt = m_enc ? ov : 32'(clamp33(33'(ov), SAT16_LO, SAT16_HI));
      end
      ST_VEL: begin
        e_nxt = m_vel ? 32'(clamp33(vdiff, -VEL_ERR_C, VEL_ERR_C))
                      : 32'(clamp33(vdiff, SAT16_LO, SAT16_HI));
      end
      ST_ACC: begin
        case (mode_r)
          MODE_POS_PI: begin
            s_nxt  = 32'(clamp33(33'(e_r) + 33'(pos_sum_r[idx_r]), SAT32_LO, SAT32_HI));
            g2_nxt = 32'(ki_r);
          end
          MODE_VEL_PI: begin
            s_nxt  = 32'(clamp33(33'(vd) + 33'(vel_sum_r[idx_r]), -VEL_SUM_C, VEL_SUM_C));
            g2_nxt = 32'(ki_r);
          end
          MODE_CASCADE: begin
            s_nxt  = 32'(clamp33(33'(vd) + 33'(vel_sum_r[idx_r]), -VEL_SUM_C, VEL_SUM_C));
            g2_nxt = ki19;
          end
          MODE_LEG_ODD, MODE_LEG_SYM: begin
            s_nxt  = 32'(clamp33(33'(vd) - 33'(last_ve_r[idx_r]), -DIFF_C, DIFF_C));
            g2_nxt = kd19;
          end
          default: begin
            s_nxt  = 32'(clamp33(33'(e_r) + 33'(enc_sum_r[idx_r]), SAT32_LO, SAT32_HI));
            g2_nxt = 32'(ki_enc_r);
          end
        endcase
      end
      ST_MUL1: begin
        mul_a = m_kp_grp ? 32'(kp_r) : 32'(kp_enc_r);
        mul_b = e_mag;
        p_nxt = mul_p;
      end
      ST_MUL2: begin
        // retire the first term while the second product is formed
        t1_nxt = signed_term(p_r[TERM_W+6:8], e_r[31]);
        mul_a  = g2_r;
        mul_b  = s_mag;
        p_nxt  = mul_p;
      end
      ST_RCP2: begin
        mul_a = RECIP_10;
        mul_b = p_r[39:8];
        p_nxt = mul_p;
      end
      ST_TERM2: begin
        t2_nxt = m_div10 ? signed_term((TERM_W-1)'(p_r[63:35]), s_r[31])
                         : signed_term(p_r[TERM_W+6:8], s_r[31]);
      end
      ST_SUM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cur};
          out_motor_nxt = motor_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        byp_r <= !(motor_ok && mode_ok);
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r         <= e_nxt;
    s_r         <= s_nxt;
    p_r         <= p_nxt;
    g2_r        <= g2_nxt;
    t1_r        <= t1_nxt;
    t2_r        <= t2_nxt;
    out_data_r  <= out_data_nxt;
    out_motor_r <= out_motor_nxt;
  end

  // Commit the per-motor state once the accumulate step has its value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        pos_sum_r[i] <= '0;
        enc_sum_r[i] <= '0;
        vel_sum_r[i] <= '0;
        last_ve_r[i] <= '0;
      end
    end else if (state_r == ST_ACC) begin
      case (mode_r)
        MODE_POS_PI:                pos_sum_r[idx_r] <= s_nxt;
        MODE_VEL_PI, MODE_CASCADE:  vel_sum_r[idx_r] <= s_nxt[15:0];
        MODE_LEG_ODD, MODE_LEG_SYM: last_ve_r[idx_r] <= vd;
        MODE_ENC_PI:                enc_sum_r[idx_r] <= s_nxt;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_motor_r;

endmodule

// ===== sv/mmcc_checker.sv =====
// Port checker for the multi-mode motor current controller, bound to the top level.
// Depends on mmcc_pkg and multi_mode_motor_current_controller_macros.svh.
`include "multi_mode_motor_current_controller_macros.svh"

module mmcc_checker #(
  parameter int MOTOR_COUNT = mmcc_pkg::MOTOR_COUNT_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mmcc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [mmcc_pkg::MOTOR_W-1:0]     out_tuser
);
  import mmcc_pkg::*;

  // current command never leaves the saturation window
  `MMCC_ASSERT_SAME(a_cur_range, out_tvalid, ($signed(out_tdata[CUR_W-1:0]) <= CUR_W'(OUT_LIMIT)) && ($signed(out_tdata[CUR_W-1:0]) >= -CUR_W'(OUT_LIMIT)), "drive current outside limit")

  // a motor beyond the configured count gets a zero command
  `MMCC_ASSERT_SAME(a_bad_motor_zero, out_tvalid && (32'(out_tuser) >= MOTOR_COUNT), out_tdata == 16'd0, "nonzero command for absent motor")

  // one item at a time: ready drops right after an accept
  `MMCC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready held after accept")

  // a stalled result holds
  `MMCC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind multi_mode_motor_current_controller mmcc_checker #(
  .MOTOR_COUNT(MOTOR_COUNT)
) u_mmcc_checker (.*);

// ===== tb/mmcc_current_checker.sv =====
// Scoreboard for the multi-mode motor current controller: tracks register
// writes, predicts the current command of every accepted tick and compares it
// with the result channel. Depends on mmcc_pkg.
module mmcc_current_checker
  import mmcc_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // target[31:0], measured[63:32], speed[79:64]
  input  logic [MOTOR_W-1:0]     in_tuser,   // motor_index[1:0]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // drive_current[14:0], zero[15]
  input  logic [MOTOR_W-1:0]     out_tuser,  // out_motor[1:0]
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     outstanding,
  output int                     commands_checked
);

  localparam int REPORT_CAP = 200;
  localparam longint S32_MAX = 64'sh7FFF_FFFF;
  localparam longint S32_MIN = -64'sh8000_0000;
  localparam longint S16_MAX = 32767;
  localparam longint S16_MIN = -32768;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic [CUR_W-1:0]   current;
  } command_t;

  command_t expected_commands[$];

  logic [MODE_W-1:0] mode_r;
  logic [GAIN_W-1:0] kp_r, ki_r, k_outer_r, k_leg_r, kp_enc_r, ki_enc_r, kd_enc_r;

  longint pos_sum [MOTOR_COUNT];
  longint vel_sum [MOTOR_COUNT];
  longint enc_sum [MOTOR_COUNT];
  longint last_vel_err [MOTOR_COUNT];

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_s32(longint v);
    return clip(v, S32_MIN, S32_MAX);
  endfunction

  function automatic longint sat_s16(longint v);
    return clip(v, S16_MIN, S16_MAX);
  endfunction

  // Q8.8 gain product, truncated toward zero
  function automatic longint gain_mul(longint gain, longint x, longint div);
    return (gain * x) / div;
  endfunction

  // Current command for one tick; advances the per-motor integrals
  function automatic longint drive_current_of(int unsigned motor, longint tgt, longint meas,
                                              longint spd);
    longint err, tv, vd, dd, acc, cur;
    cur = 0;
    if (motor < MOTOR_COUNT) begin
      case (mode_r)
        MODE_POS_PI: begin
          err = sat_s32(tgt - meas);
          acc = sat_s32(err + pos_sum[motor]);
          pos_sum[motor] = acc;
          cur = sat_s16(gain_mul(kp_r, err, 256) + gain_mul(ki_r, acc, 256));
        end
        MODE_VEL_PI: begin
          tv = sat_s16(tgt);
          vd = clip(tv - spd, -VEL_ERR_LIMIT, VEL_ERR_LIMIT);
          acc = clip(vd + vel_sum[motor], -VEL_SUM_LIMIT, VEL_SUM_LIMIT);
          vel_sum[motor] = acc;
          cur = sat_s16(gain_mul(kp_r, vd, 256) + gain_mul(ki_r, acc, 2560));
        end
        MODE_CASCADE: begin
          err = clip(sat_s32(tgt - meas), -CASCADE_ERR_LIMIT, CASCADE_ERR_LIMIT);
          tv = sat_s16(gain_mul(k_outer_r, err, 25600));
          vd = sat_s16(tv - spd);
          acc = clip(vd + vel_sum[motor], -VEL_SUM_LIMIT, VEL_SUM_LIMIT);
          vel_sum[motor] = acc;
          cur = sat_s16(gain_mul(kp_r, vd, 256) + gain_mul(19 * ki_r, acc, 2560));
        end
        MODE_LEG_ODD, MODE_LEG_SYM: begin
          err = sat_s32(tgt - meas);
          if (mode_r == MODE_LEG_ODD) begin
            // lopsided clamp: above the high bound folds down to the low value
            if (err > LEG_HI) err = LEG_ODD_VALUE;
            if (err < -LEG_ODD_VALUE) err = -LEG_ODD_VALUE;
          end else begin
            err = clip(err, -LEG_HI, LEG_HI);
          end
          tv = sat_s16(gain_mul(k_leg_r, err, 256));
          vd = sat_s16(tv - spd);
          dd = clip(vd - last_vel_err[motor], -DIFF_LIMIT, DIFF_LIMIT);
          last_vel_err[motor] = vd;
          cur = sat_s16(gain_mul(kp_enc_r, vd, 256) + gain_mul(19 * kd_enc_r, dd, 2560));
        end
        MODE_ENC_PI: begin
          err = sat_s32((tgt - meas) / 3);
          acc = sat_s32(err + enc_sum[motor]);
          enc_sum[motor] = acc;
          cur = clip(gain_mul(kp_enc_r, err, 256) + gain_mul(ki_enc_r, acc, 256),
                     -ENC_OUT_LIMIT, ENC_OUT_LIMIT);
        end
        default: cur = 0;
      endcase
    end
    return clip(cur, -OUT_LIMIT, OUT_LIMIT);
  endfunction

  function automatic void report(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin : watch
    command_t want;
    longint cur;
    if (!rst_n) begin
      mode_r    = MODE_RST;
      kp_r      = KP_RST;
      ki_r      = KI_RST;
      k_outer_r = K_OUTER_RST;
      k_leg_r   = K_LEG_RST;
      kp_enc_r  = KP_ENC_RST;
      ki_enc_r  = KI_ENC_RST;
      kd_enc_r  = KD_ENC_RST;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        pos_sum[i] = 0;
        vel_sum[i] = 0;
        enc_sum[i] = 0;
        last_vel_err[i] = 0;
      end
      expected_commands.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MODE:    mode_r    = cfg_wdata[MODE_W-1:0];
          REG_KP:      kp_r      = cfg_wdata;
          REG_KI:      ki_r      = cfg_wdata;
          REG_K_OUTER: k_outer_r = cfg_wdata;
          REG_K_LEG:   k_leg_r   = cfg_wdata;
          REG_KP_ENC:  kp_enc_r  = cfg_wdata;
          REG_KI_ENC:  ki_enc_r  = cfg_wdata;
          REG_KD_ENC:  kd_enc_r  = cfg_wdata;
          default: ;
        endcase
      end
      // compare results before queuing new ticks, so a stray result never pairs up
      // with a tick accepted on the same edge
      if (out_tvalid && out_tready) begin
        commands_checked++;
        if (expected_commands.size() == 0) begin
          report("unexpected command, motor", -1, out_tuser);
        end else begin
          want = expected_commands.pop_front();
          if (out_tuser !== want.motor)
            report("motor", want.motor, out_tuser);
          if (out_tdata[CUR_W-1:0] !== want.current)
            report("drive current", $signed(want.current), $signed(out_tdata[CUR_W-1:0]));
          if (out_tdata[OUT_TDATA_W-1:CUR_W] !== '0)
            report("pad bit", 0, out_tdata[OUT_TDATA_W-1:CUR_W]);
        end
      end
      if (in_tvalid && in_tready) begin
        cur = drive_current_of(in_tuser, $signed(in_tdata[31:0]), $signed(in_tdata[63:32]),
                               $signed(in_tdata[79:64]));
        want.motor = in_tuser;
        want.current = cur[CUR_W-1:0];
        expected_commands.push_back(want);
      end
    end
    outstanding = expected_commands.size();
  end

  initial begin
    mismatches = 0;
    outstanding = 0;
    commands_checked = 0;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the motor current controller testbench: clock, reset, register setup,
// tick stimulus, output back-pressure and the verdict.
// Depends on mmcc_pkg, mmcc_current_checker and the controller RTL.
module testbench;
  import mmcc_pkg::*;

  localparam int RANDOM_PHASES   = 32;
  localparam int TICKS_PER_PHASE = 47;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 16;      // longest latency plus margin
  localparam int DRAIN_CYCLES    = 24;
  localparam int CYCLE_LIMIT     = 500000;  // slowest correct run stays well under this limit

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // target[31:0], measured[63:32], speed[79:64]
  logic [MOTOR_W-1:0]     in_tuser;   // motor_index[1:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // drive_current[14:0], zero[15]
  logic [MOTOR_W-1:0]     out_tuser;  // out_motor[1:0]
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int mismatches, outstanding, commands_checked;
  int tx_idle_pct, rx_stall_pct;
  int hold_requests, holds_served;
  int ticks_sent, settings_loaded;
  int cycle_count;

  // gain register images, indexed by register index (entry of the mode index unused)
  logic [GAIN_W-1:0] gain_set [0:7];

  multi_mode_motor_current_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  mmcc_current_checker current_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .commands_checked (commands_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles; give up at the limit
  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d commands still outstanding", cycle_count,
             outstanding);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls at the current rate; on request, hold off for a
  // long stretch so the block backs up and stalls its input.
  initial begin
    out_tready = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
      end
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Random value spread over a chosen magnitude class; the widest class
  // covers every bit of the field.
  function automatic logic [31:0] spread(int cls);
    case (cls)
      0:       return int'($urandom_range(800)) - 400;
      1:       return int'($urandom_range(10000)) - 5000;
      2:       return int'($urandom_range(80000)) - 40000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(7))
      0:       g = '0;
      1:       g = '1;
      2:       g = $urandom;
      default: g = $urandom_range(3000);
    endcase
    return g;
  endfunction

  // Offer one tick, idling beforehand at the sender's rate; return at the
  // falling edge after acceptance with valid still high.
  task automatic send_tick(input logic [MOTOR_W-1:0] motor, input logic [31:0] tgt,
                           input logic [31:0] meas, input logic [15:0] spd);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom};
      in_tuser  <= $urandom;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= motor;
    in_tdata  <= {spd, meas, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Drop valid and wait until every command has come back and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all eight registers back to back; junk in the unused mode bits
  task automatic load_settings(input logic [MODE_W-1:0] mode_code);
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] junk;
    for (int r = 0; r < 8; r++) begin
      addr = r;
      junk = $urandom;
      cfg_we   <= 1'b1;
      cfg_addr <= addr;
      if (addr == REG_MODE) cfg_wdata <= {junk[CFG_DATA_W-1:MODE_W], mode_code};
      else cfg_wdata <= gain_set[addr];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic default_gains();
    gain_set[REG_KP]      = KP_RST;
    gain_set[REG_KI]      = KI_RST;
    gain_set[REG_K_OUTER] = K_OUTER_RST;
    gain_set[REG_K_LEG]   = K_LEG_RST;
    gain_set[REG_KP_ENC]  = KP_ENC_RST;
    gain_set[REG_KI_ENC]  = KI_ENC_RST;
    gain_set[REG_KD_ENC]  = KD_ENC_RST;
  endtask

  initial begin
    logic [31:0] tgt, meas;
    logic [15:0] spd;
    int cls;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_requests = 0;
    ticks_sent = 0;
    settings_loaded = 0;
    gain_set[REG_MODE] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: symmetric leg mode with default gains, error right at the clamp
    send_tick(2'd2, 32'd360, 32'd0, 16'd0);

    // Directed: every mode code, including the two unused ones, with default
    // gains; opposite full-scale errors and speeds, then an error inside the
    // band between the odd leg clamp's two bounds.
    for (int m = 0; m < 8; m++) begin
      settle();
      default_gains();
      load_settings(m);
      send_tick(2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
      send_tick(2'd3, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
      send_tick(2'd1, 32'd330, 32'd0, 16'd0);
    end

    // Random phases: each mode under each idle pattern, gains mostly moderate,
    // with all-zero and all-max settings mixed in.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      for (int r = 1; r < 8; r++) gain_set[r] = pick_gain();
      if (p % 11 == 5) for (int r = 1; r < 8; r++) gain_set[r] = '1;
      if (p % 11 == 10) for (int r = 1; r < 8; r++) gain_set[r] = '0;
      load_settings(p % 8);
      case ((p / 8) % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
      endcase
      // hold the result side off while the sender keeps pushing
      if (p == 2 || p == 27) hold_requests++;
      repeat (TICKS_PER_PHASE) begin
        cls = $urandom_range(3);
        tgt = spread(cls);
        // bias toward small errors so the integrators stay out of saturation
        if ($urandom_range(3) == 0) meas = tgt - spread(0);
        else meas = spread($urandom_range(3));
        if ($urandom_range(3) == 0) spd = $urandom;
        else spd = int'($urandom_range(2400)) - 1200;
        send_tick($urandom, tgt, meas, spd);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d control ticks over %0d register settings (all eight mode codes,",
             ticks_sent, settings_loaded);
    $display("four idle patterns, %0d long output hold-offs); %0d commands checked",
             hold_requests, commands_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
